[src/nearest_neighbor_image_scaler_macros.svh]
// Assertion macros shared by the scaler RTL.
// No dependencies; take in by `include where assertions are written.
`ifndef NEAREST_NEIGHBOR_IMAGE_SCALER_MACROS_SVH
`define NEAREST_NEIGHBOR_IMAGE_SCALER_MACROS_SVH

// check on every clock edge outside reset
`define NNS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// check on every clock edge, reset included
`define NNS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

[src/nns_pkg.sv]
// Types, sizes and register codes of the nearest neighbor image scaler.
// No dependencies; used by every module of the block but nns_ram.
package nns_pkg;

    localparam int MAX_SIDE    = 128;
    localparam int MAX_PLANES  = 4;
    localparam int SAMPLE_BITS = 16;

    localparam int PLANE_W  = 2;
    localparam int COORD_W  = 10;
    localparam int SAMPLE_W = 16;
    localparam int SRC_W    = 8;
    localparam int DST_W    = 11;
    localparam int CH_W     = 3;

    localparam int ROW_W       = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int STORE_DEPTH = MAX_PLANES * MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int PROD_W      = COORD_W + SRC_W;
    localparam int LIM_W       = DST_W + ROW_W + 1;
    localparam int CMP_W       = (PROD_W > LIM_W) ? PROD_W : LIM_W;
    localparam int DIV_W       = (PROD_W > DST_W + ROW_W) ? PROD_W : DST_W + ROW_W;
    localparam int DIV_STAGES  = ROW_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int REG_W   = 3;

    typedef enum logic [REG_W-1:0] {
        REG_SRC_HEIGHT    = 3'd0,
        REG_SRC_WIDTH     = 3'd1,
        REG_DST_HEIGHT    = 3'd2,
        REG_DST_WIDTH     = 3'd3,
        REG_CHANNEL_COUNT = 3'd4
    } t_reg_idx;

    typedef enum logic {
        MODE_WRITE = 1'b0,
        MODE_READ  = 1'b1
    } t_mode;

    typedef struct packed {
        t_mode                 mode;
        logic [PLANE_W-1:0]    plane;
        logic [COORD_W-1:0]    row_index;
        logic [COORD_W-1:0]    col_index;
        logic [SAMPLE_W-1:0]   sample_in;
    } t_in;

    typedef struct packed {
        logic [SAMPLE_W-1:0]   sample_out;
        logic                  out_of_range;
    } t_out;

    typedef struct packed {
        logic [SRC_W-1:0]      src_height;
        logic [SRC_W-1:0]      src_width;
        logic [DST_W-1:0]      dst_height;
        logic [DST_W-1:0]      dst_width;
        logic [CH_W-1:0]       channel_count;
    } t_cfg;

    typedef struct packed {
        logic                  is_read;
        logic                  ok;
        logic [PLANE_W-1:0]    plane;
        logic [ROW_W-1:0]      wr_row;
        logic [ROW_W-1:0]      wr_col;
        logic [PROD_W-1:0]     prod_row;
        logic [PROD_W-1:0]     prod_col;
        logic [SAMPLE_BITS-1:0] sample;
    } t_cmd;

    typedef struct packed {
        logic                  is_read;
        logic                  ok;
        logic [PLANE_W-1:0]    plane;
        logic [ROW_W-1:0]      wr_row;
        logic [ROW_W-1:0]      wr_col;
        logic [DIV_W-1:0]      rem_row;
        logic [DIV_W-1:0]      rem_col;
        logic [ROW_W-1:0]      q_row;
        logic [ROW_W-1:0]      q_col;
        logic [SAMPLE_BITS-1:0] sample;
    } t_stage;

endpackage

[src/nns_ram.sv]
// Generic single port RAM with registered read data.
// No dependencies.
module nns_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                         i_wdata,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/nns_front.sv]
// Front end: range checks and coordinate products for one incoming item.
// Depends on nns_pkg.
module nns_front (
    input  nns_pkg::t_cfg i_cfg,
    input  nns_pkg::t_in  i_item,
    output nns_pkg::t_cmd o_cmd
);

    logic plane_ok;
    logic wr_ok;
    logic rd_ok;

    always_comb begin
        plane_ok = ({1'b0, i_item.plane} < i_cfg.channel_count)
                && (32'(i_item.plane) < nns_pkg::MAX_PLANES);
        wr_ok = plane_ok
             && (i_item.row_index < nns_pkg::COORD_W'(i_cfg.src_height))
             && (i_item.col_index < nns_pkg::COORD_W'(i_cfg.src_width))
             && (32'(i_item.row_index) < nns_pkg::MAX_SIDE)
             && (32'(i_item.col_index) < nns_pkg::MAX_SIDE);
        rd_ok = plane_ok
             && (nns_pkg::DST_W'(i_item.row_index) < i_cfg.dst_height)
             && (nns_pkg::DST_W'(i_item.col_index) < i_cfg.dst_width);

        o_cmd.is_read  = (i_item.mode == nns_pkg::MODE_READ);
        o_cmd.ok       = (i_item.mode == nns_pkg::MODE_READ) ? rd_ok : wr_ok;
        o_cmd.plane    = i_item.plane;
        o_cmd.wr_row   = nns_pkg::ROW_W'(i_item.row_index);
        o_cmd.wr_col   = nns_pkg::ROW_W'(i_item.col_index);
        o_cmd.prod_row = nns_pkg::PROD_W'(i_item.row_index)
                       * nns_pkg::PROD_W'(i_cfg.src_height);
        o_cmd.prod_col = nns_pkg::PROD_W'(i_item.col_index)
                       * nns_pkg::PROD_W'(i_cfg.src_width);
        o_cmd.sample   = nns_pkg::SAMPLE_BITS'(i_item.sample_in);
    end

endmodule

[src/nns_queue.sv]
// Two-entry command queue between front end and back end.
// Depends on nns_pkg and the assertion macro header.
`include "nearest_neighbor_image_scaler_macros.svh"

module nns_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  nns_pkg::t_cmd i_push_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output nns_pkg::t_cmd o_cmd
);

    nns_pkg::t_cmd                r_mem [nns_pkg::QUEUE_DEPTH];
    logic [nns_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [nns_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [nns_pkg::QCNT_W-1:0]   r_count;
    logic [nns_pkg::QCNT_W-1:0]   n_count;
    logic                         do_pop;

    assign o_full  = (r_count == nns_pkg::QCNT_W'(nns_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (i_push && !do_pop) begin
            n_count = r_count + nns_pkg::QCNT_W'(1);
        end else if (!i_push && do_pop) begin
            n_count = r_count - nns_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + nns_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + nns_pkg::QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    `NNS_ASSERT_ALWAYS(a_count_bound, (!i_rst_n || (r_count <= nns_pkg::QCNT_W'(nns_pkg::QUEUE_DEPTH))), "queue count overflow")
    `NNS_ASSERT(a_push_grows, (i_push && !do_pop) |=> r_count == $past(r_count) + nns_pkg::QCNT_W'(1), "push lost")

endmodule

[src/nns_back.sv]
// Back end: source position dividers, sample store and result register.
// Depends on nns_pkg, nns_ram and the assertion macro header.
`include "nearest_neighbor_image_scaler_macros.svh"

module nns_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  nns_pkg::t_cfg i_cfg,
    input  logic          i_q_valid,
    input  nns_pkg::t_cmd i_q_cmd,
    output logic          o_q_pop,
    output logic          o_result_valid,
    output nns_pkg::t_out o_result
);

    localparam int LAST = nns_pkg::DIV_STAGES;

    function automatic logic [nns_pkg::ADDR_W-1:0] store_addr(
        input logic [nns_pkg::PLANE_W-1:0] plane,
        input logic [nns_pkg::ROW_W-1:0]   row,
        input logic [nns_pkg::ROW_W-1:0]   col
    );
        return nns_pkg::ADDR_W'(plane)
             * nns_pkg::ADDR_W'(nns_pkg::MAX_SIDE * nns_pkg::MAX_SIDE)
             + nns_pkg::ADDR_W'(row) * nns_pkg::ADDR_W'(nns_pkg::MAX_SIDE)
             + nns_pkg::ADDR_W'(col);
    endfunction

    nns_pkg::t_stage                  r_stage [LAST+1];
    logic [LAST:0]                    r_valid;
    nns_pkg::t_stage                  n_stage0;
    logic [nns_pkg::CMP_W-1:0]        lim_row;
    logic [nns_pkg::CMP_W-1:0]        lim_col;
    logic                             ram_we;
    logic [nns_pkg::ADDR_W-1:0]       ram_addr;
    logic [nns_pkg::SAMPLE_BITS-1:0]  ram_rdata;
    logic                             r_ram_valid;
    logic                             r_ram_ok;
    logic                             r_out_valid;
    nns_pkg::t_out                    r_out;

    assign o_q_pop = i_q_valid;

    always_comb begin
        lim_row = nns_pkg::CMP_W'(i_cfg.dst_height) * nns_pkg::CMP_W'(nns_pkg::MAX_SIDE);
        lim_col = nns_pkg::CMP_W'(i_cfg.dst_width) * nns_pkg::CMP_W'(nns_pkg::MAX_SIDE);
        n_stage0.is_read = i_q_cmd.is_read;
        n_stage0.ok      = i_q_cmd.ok && (!i_q_cmd.is_read
                        || ((nns_pkg::CMP_W'(i_q_cmd.prod_row) < lim_row)
                        &&  (nns_pkg::CMP_W'(i_q_cmd.prod_col) < lim_col)));
        n_stage0.plane   = i_q_cmd.plane;
        n_stage0.wr_row  = i_q_cmd.wr_row;
        n_stage0.wr_col  = i_q_cmd.wr_col;
        n_stage0.rem_row = nns_pkg::DIV_W'(i_q_cmd.prod_row);
        n_stage0.rem_col = nns_pkg::DIV_W'(i_q_cmd.prod_col);
        n_stage0.q_row   = '0;
        n_stage0.q_col   = '0;
        n_stage0.sample  = i_q_cmd.sample;
    end

    always_ff @(posedge i_clk) begin
        r_stage[0] <= n_stage0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else begin
            r_valid[0] <= i_q_valid;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar s = 0; s < LAST; s++) begin : g_div
        localparam int BIT = LAST - 1 - s;
        nns_pkg::t_stage           n_stage;
        logic [nns_pkg::DIV_W-1:0] trial_row;
        logic [nns_pkg::DIV_W-1:0] trial_col;

        always_comb begin
            trial_row = nns_pkg::DIV_W'(i_cfg.dst_height) << BIT;
            trial_col = nns_pkg::DIV_W'(i_cfg.dst_width) << BIT;
            n_stage   = r_stage[s];
            if (r_stage[s].rem_row >= trial_row) begin
                n_stage.rem_row    = r_stage[s].rem_row - trial_row;
                n_stage.q_row[BIT] = 1'b1;
            end
            if (r_stage[s].rem_col >= trial_col) begin
                n_stage.rem_col    = r_stage[s].rem_col - trial_col;
                n_stage.q_col[BIT] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            r_stage[s+1] <= n_stage;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s+1] <= 1'b0;
            end else begin
                r_valid[s+1] <= r_valid[s];
            end
        end
    end

    always_comb begin
        ram_we   = r_valid[LAST] && !r_stage[LAST].is_read && r_stage[LAST].ok;
        ram_addr = r_stage[LAST].is_read
                 ? store_addr(r_stage[LAST].plane, r_stage[LAST].q_row, r_stage[LAST].q_col)
                 : store_addr(r_stage[LAST].plane, r_stage[LAST].wr_row,
                              r_stage[LAST].wr_col);
    end

    nns_ram #(
        .WIDTH (nns_pkg::SAMPLE_BITS),
        .DEPTH (nns_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_stage[LAST].sample),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        r_ram_ok <= r_stage[LAST].ok;
        r_out.sample_out   <= r_ram_ok ? nns_pkg::SAMPLE_W'(ram_rdata) : '0;
        r_out.out_of_range <= !r_ram_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_ram_valid <= r_valid[LAST] && r_stage[LAST].is_read;
            r_out_valid <= r_ram_valid;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    `NNS_ASSERT(a_oor_zero, (r_out_valid && r_out.out_of_range) |-> (r_out.sample_out == '0), "out of range result carries data")
    `NNS_ASSERT(a_oor_follows, (r_ram_valid && !r_ram_ok) |=> (r_out_valid && r_out.out_of_range), "rejected read lost")

endmodule

[src/nearest_neighbor_image_scaler.sv]
// Top level of the nearest neighbor image scaler: config registers and wiring.
// Depends on nns_pkg, nns_front, nns_queue and nns_back.
//
//  channel   handshake                      payload
//  item in   start & !busy                  i_item (t_in)
//  result    o_result_valid, one cycle      o_result (t_out)
//  config    psel & penable & pwrite        paddr, pwdata; prdata, pready
//
// One item per cycle while busy is low; a read's result is strobed after it passes the
// queue, input stage, one-quotient-bit divider stages, RAM read and result registers.
// Writes give no result and pass the same pipeline, so store order follows item order.
// Reset loads the default sizes and empties the pipeline; the sample store is not cleared.
// busy rises only when the two-entry queue is full; the back end never stalls.
module nearest_neighbor_image_scaler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  nns_pkg::t_in                  i_item,
    output logic                          o_result_valid,
    output nns_pkg::t_out                 o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nns_pkg::PADDR_W-1:0]   paddr,
    input  logic [nns_pkg::PDATA_W-1:0]   pwdata,
    output logic [nns_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    nns_pkg::t_cfg     r_cfg;
    nns_pkg::t_reg_idx reg_idx;
    nns_pkg::t_cmd     front_cmd;
    nns_pkg::t_cmd     q_cmd;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;
    logic              accept;

    assign pready  = 1'b1;
    assign reg_idx = nns_pkg::t_reg_idx'(paddr[nns_pkg::PADDR_W-1:2]);
    assign busy    = q_full;
    assign accept  = start && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_height    <= nns_pkg::SRC_W'(128);
            r_cfg.src_width     <= nns_pkg::SRC_W'(128);
            r_cfg.dst_height    <= nns_pkg::DST_W'(128);
            r_cfg.dst_width     <= nns_pkg::DST_W'(128);
            r_cfg.channel_count <= nns_pkg::CH_W'(1);
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                nns_pkg::REG_SRC_HEIGHT:    r_cfg.src_height    <= pwdata[nns_pkg::SRC_W-1:0];
                nns_pkg::REG_SRC_WIDTH:     r_cfg.src_width     <= pwdata[nns_pkg::SRC_W-1:0];
                nns_pkg::REG_DST_HEIGHT:    r_cfg.dst_height    <= pwdata[nns_pkg::DST_W-1:0];
                nns_pkg::REG_DST_WIDTH:     r_cfg.dst_width     <= pwdata[nns_pkg::DST_W-1:0];
                nns_pkg::REG_CHANNEL_COUNT: r_cfg.channel_count <= pwdata[nns_pkg::CH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            nns_pkg::REG_SRC_HEIGHT:    prdata = nns_pkg::PDATA_W'(r_cfg.src_height);
            nns_pkg::REG_SRC_WIDTH:     prdata = nns_pkg::PDATA_W'(r_cfg.src_width);
            nns_pkg::REG_DST_HEIGHT:    prdata = nns_pkg::PDATA_W'(r_cfg.dst_height);
            nns_pkg::REG_DST_WIDTH:     prdata = nns_pkg::PDATA_W'(r_cfg.dst_width);
            nns_pkg::REG_CHANNEL_COUNT: prdata = nns_pkg::PDATA_W'(r_cfg.channel_count);
            default:                    prdata = '0;
        endcase
    end

    nns_front u_front (
        .i_cfg  (r_cfg),
        .i_item (i_item),
        .o_cmd  (front_cmd)
    );

    nns_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept),
        .i_push_cmd (front_cmd),
        .i_pop      (q_pop),
        .o_full     (q_full),
        .o_valid    (q_valid),
        .o_cmd      (q_cmd)
    );

    nns_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_valid      (q_valid),
        .i_q_cmd        (q_cmd),
        .o_q_pop        (q_pop),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

[bench/tb_nearest_neighbor_image_scaler.sv]
// Testbench for nearest_neighbor_image_scaler: directed and random store/read items,
// APB register writes between phases, and an in-order scoreboard of scaled pixels.
// Depends on nns_pkg and the scaler RTL.
`timescale 1ns / 100ps

module tb_nearest_neighbor_image_scaler;
    import nns_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 6;
    localparam int SETTLE_CYCLES  = 24;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int REPORT_LIMIT   = 10;
    localparam int REG_UNMAPPED   = 7;

    class pixel_scoreboard;
        logic [SAMPLE_W-1:0] image [STORE_DEPTH];
        bit                  filled [STORE_DEPTH];
        t_out                pending_pixels [$];
        int unsigned         src_h, src_w, dst_h, dst_w, planes;
        int                  mismatches;

        function new();
            src_h      = 128;
            src_w      = 128;
            dst_h      = 128;
            dst_w      = 128;
            planes     = 1;
            mismatches = 0;
        endfunction

        function void set_reg(int idx, int unsigned val);
            case (idx)
                REG_SRC_HEIGHT:    src_h  = val & 32'hFF;
                REG_SRC_WIDTH:     src_w  = val & 32'hFF;
                REG_DST_HEIGHT:    dst_h  = val & 32'h7FF;
                REG_DST_WIDTH:     dst_w  = val & 32'h7FF;
                REG_CHANNEL_COUNT: planes = val & 32'h7;
                default: ;
            endcase
        endfunction

        function bit plane_ok(int unsigned p);
            return p < planes && p < MAX_PLANES;
        endfunction

        // store address of a write that lands, 0 return when it is dropped
        function bit store_addr(t_in it, output int unsigned addr);
            addr = (int'(it.plane) * MAX_SIDE + int'(it.row_index)) * MAX_SIDE
                   + int'(it.col_index);
            return plane_ok(it.plane) && it.row_index < src_h && it.col_index < src_w
                   && it.row_index < MAX_SIDE && it.col_index < MAX_SIDE;
        endfunction

        // store address behind a scaled pixel, 0 return when out of range
        function bit source_addr(t_in it, output int unsigned addr);
            int unsigned srow, scol;
            addr = 0;
            if (!plane_ok(it.plane) || it.row_index >= dst_h || it.col_index >= dst_w)
                return 0;
            srow = (int'(it.row_index) * src_h) / dst_h;
            scol = (int'(it.col_index) * src_w) / dst_w;
            if (srow >= MAX_SIDE || scol >= MAX_SIDE)
                return 0;
            addr = (int'(it.plane) * MAX_SIDE + srow) * MAX_SIDE + scol;
            return 1;
        endfunction

        function bit note_item(t_in it);
            int unsigned addr;
            t_out        px;
            if (it.mode == MODE_WRITE) begin
                if (!store_addr(it, addr))
                    return 0;
                image[addr]  = it.sample_in;
                filled[addr] = 1'b1;
                return 1;
            end
            px.sample_out   = '0;
            px.out_of_range = 1'b1;
            if (source_addr(it, addr)) begin
                px.sample_out   = image[addr];
                px.out_of_range = 1'b0;
            end
            pending_pixels.push_back(px);
            return 1;
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (pending_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected pixel: sample %h oor %b",
                             got.sample_out, got.out_of_range);
                return;
            end
            want = pending_pixels.pop_front();
            if (got.sample_out !== want.sample_out || got.out_of_range !== want.out_of_range) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("pixel mismatch: expected sample %h oor %b, got sample %h oor %b",
                             want.sample_out, want.out_of_range,
                             got.sample_out, got.out_of_range);
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_in                  i_item;
    logic                 o_result_valid;
    t_out                 o_result;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    pixel_scoreboard      sb;
    int                   useful_items;
    int                   cycle_count;

    nearest_neighbor_image_scaler DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid)
            sb.check_result(o_result);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[nearest_neighbor_image_scaler] ERROR");
            $finish;
        end
    end

    function automatic t_in make_item(t_mode m, int p, int r, int c, int s);
        t_in it;
        it.mode      = m;
        it.plane     = PLANE_W'(p);
        it.row_index = COORD_W'(r);
        it.col_index = COORD_W'(c);
        it.sample_in = SAMPLE_W'(s);
        return it;
    endfunction

    function automatic t_in random_item();
        t_in         it;
        int unsigned rows, cols, used;
        it.mode = ($urandom_range(0, 99) < 60) ? MODE_READ : MODE_WRITE;
        used    = (sb.planes < MAX_PLANES) ? sb.planes : MAX_PLANES;
        if (used != 0 && $urandom_range(0, 9) != 0)
            it.plane = PLANE_W'($urandom_range(0, used - 1));
        else
            it.plane = PLANE_W'($urandom_range(0, 3));
        if (it.mode == MODE_READ) begin
            rows = sb.dst_h;
            cols = sb.dst_w;
        end else begin
            rows = (sb.src_h < MAX_SIDE) ? sb.src_h : MAX_SIDE;
            cols = (sb.src_w < MAX_SIDE) ? sb.src_w : MAX_SIDE;
        end
        it.row_index = COORD_W'((rows != 0 && $urandom_range(0, 9) != 0) ?
                       $urandom_range(0, rows - 1) : $urandom_range(0, 1023));
        it.col_index = COORD_W'((cols != 0 && $urandom_range(0, 9) != 0) ?
                       $urandom_range(0, cols - 1) : $urandom_range(0, 1023));
        it.sample_in = SAMPLE_W'($urandom_range(0, 65535));
        return it;
    endfunction

    // hold start high until the item is taken, leave it high on return
    task automatic send_item(input t_in it);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        void'(sb.note_item(it));
        useful_items++;
    endtask

    // store the source sample first when a read would land on an unwritten entry
    task automatic send_pixel_item(input t_in it);
        int unsigned addr;
        if (it.mode == MODE_READ && sb.source_addr(it, addr) && !sb.filled[addr])
            send_item(make_item(MODE_WRITE, it.plane, (addr / MAX_SIDE) % MAX_SIDE,
                                addr % MAX_SIDE, $urandom_range(0, 65535)));
        send_item(it);
    endtask

    task automatic hold_off(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_results();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending_pixels.size() != 0);
    endtask

    task automatic settle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input int idx, input int unsigned val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx * 4);
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input int sh, input int sw, input int dh, input int dw,
                             input int ch);
        write_reg(REG_SRC_HEIGHT, sh);
        write_reg(REG_SRC_WIDTH, sw);
        write_reg(REG_DST_HEIGHT, dh);
        write_reg(REG_DST_WIDTH, dw);
        write_reg(REG_CHANNEL_COUNT, ch);
    endtask

    task automatic run_phase(input int target, input int gap_max);
        int  first, burst;
        bit  paused;
        first  = useful_items;
        burst  = $urandom_range(1, 16);
        paused = 1'b0;
        while (useful_items - first < target) begin
            send_pixel_item(random_item());
            burst--;
            if (burst == 0) begin
                if (gap_max > 0)
                    hold_off($urandom_range(1, gap_max));
                burst = $urandom_range(1, 16);
            end
            if (!paused && useful_items - first >= target / 2) begin
                wait_results();
                paused = 1'b1;
            end
        end
        settle();
    endtask

    initial begin
        sb           = new();
        useful_items = 0;
        cycle_count  = 0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_item       = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(make_item(MODE_WRITE, 0, 0, 0, 16'hFFFF));
        send_item(make_item(MODE_WRITE, 0, 127, 127, 16'h0000));
        send_item(make_item(MODE_WRITE, 0, 0, 127, 16'hA5A5));
        send_item(make_item(MODE_WRITE, 0, 127, 0, 16'h5A5A));
        send_item(make_item(MODE_WRITE, 0, 64, 64, 16'h8001));
        send_item(make_item(MODE_READ, 0, 0, 0, 16'hFFFF));
        send_item(make_item(MODE_READ, 0, 127, 127, 16'h0000));
        send_item(make_item(MODE_READ, 0, 0, 127, 16'h1234));
        send_item(make_item(MODE_READ, 0, 127, 0, 16'h0000));
        send_item(make_item(MODE_READ, 0, 64, 64, 16'hFFFF));
        send_item(make_item(MODE_WRITE, 1, 1, 1, 16'h7777));
        send_item(make_item(MODE_WRITE, 0, 128, 5, 16'h6666));
        send_item(make_item(MODE_WRITE, 3, 1023, 1023, 16'h5555));
        send_item(make_item(MODE_READ, 1, 0, 0, 16'h0000));
        send_item(make_item(MODE_READ, 3, 5, 5, 16'h0000));
        send_item(make_item(MODE_READ, 0, 128, 0, 16'h0000));
        send_item(make_item(MODE_READ, 0, 0, 128, 16'h0000));
        send_item(make_item(MODE_READ, 0, 1023, 1023, 16'hFFFF));
        send_item(make_item(MODE_WRITE, 0, 0, 0, 16'h1234));
        send_item(make_item(MODE_READ, 0, 0, 0, 16'h0000));
        settle();

        write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
        send_item(make_item(MODE_READ, 0, 127, 127, 16'h0000));
        settle();

        configure(1, 1, 1, 1, 1);
        run_phase(90, 0);
        configure(128, 128, 1024, 1024, 4);
        run_phase(130, 4);
        configure(37, 100, 5, 700, 3);
        run_phase(100, 8);
        configure(255, 200, 128, 64, 7);
        run_phase(100, 3);
        configure(64, 64, 0, 50, 4);
        run_phase(60, 5);
        configure(16, 16, 32, 0, 0);
        run_phase(60, 2);
        repeat (3) begin
            configure($urandom_range(1, 128), $urandom_range(1, 128),
                      $urandom_range(1, 1024), $urandom_range(1, 1024),
                      $urandom_range(1, 4));
            run_phase(120, $urandom_range(0, 6));
        end

        if (sb.mismatches == 0 && sb.pending_pixels.size() == 0)
            $display("[nearest_neighbor_image_scaler] OK");
        else
            $display("[nearest_neighbor_image_scaler] ERROR");
        $finish;
    end

endmodule

[nearest_neighbor_image_scaler.f]
+incdir+src
src/nns_pkg.sv
src/nns_ram.sv
src/nns_front.sv
src/nns_queue.sv
src/nns_back.sv
src/nearest_neighbor_image_scaler.sv
bench/tb_nearest_neighbor_image_scaler.sv
